// ===== sv/tlbl_pkg.sv =====
// Shared constants and types for the TLB address translator.
// Used by tlbl_lru and tlb_lru_page_translator; depends on nothing else.
`default_nettype none

package tlbl_pkg;

  localparam int ADDR_W      = 16;
  localparam int OFFSET_BITS = 8;
  localparam int FRAME_BITS  = ADDR_W - OFFSET_BITS;
  localparam int PAGE_COUNT  = 256;
  localparam int PAGE_BITS   = $clog2(PAGE_COUNT);
  localparam int TLB_ENTRIES = 16;
  localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
  localparam int TLB_USED_W  = $clog2(TLB_ENTRIES + 1);

  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] frame;
  } tlbl_lookup_t;

endpackage

`default_nettype wire

// ===== sv/tlbl_lru.sv =====
// TLB storage kept in least-recently-used order, with lookup and reorder logic.
// Depends on tlbl_pkg.
`default_nettype none

module tlbl_lru
  import tlbl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [PAGE_BITS-1:0]  page,
  input  logic                  update,
  input  logic [FRAME_BITS-1:0] frame,
  output tlbl_lookup_t          lookup
);

  logic [PAGE_BITS-1:0]  tlb_page  [TLB_ENTRIES];
  logic [FRAME_BITS-1:0] tlb_frame [TLB_ENTRIES];
  logic [TLB_USED_W-1:0] tlb_used;
  logic [TLB_USED_W-1:0] tlb_used_next;

  logic [TLB_ENTRIES-1:0] match;
  logic                   hit;
  logic [TLB_IDX_W-1:0]   hit_idx;
  logic                   full;
  logic                   shift_en;
  logic [TLB_USED_W-1:0]  shift_from;
  logic [TLB_USED_W-1:0]  last;

  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match[i] = (TLB_USED_W'(i) < tlb_used) && (tlb_page[i] == page);
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = TLB_IDX_W'(i);
      end
    end
  end

  assign full       = (tlb_used == TLB_USED_W'(TLB_ENTRIES));
  assign shift_en   = hit || full;
  assign shift_from = hit ? TLB_USED_W'(hit_idx) : '0;
  assign last       = shift_en ? (tlb_used - 1'b1) : tlb_used;

  assign lookup.hit   = hit;
  assign lookup.frame = tlb_frame[hit_idx];

  // Entries between the removed slot and the last slot move down by one, and
  // the entry just used goes to the most recently used slot.
  for (genvar k = 0; k < TLB_ENTRIES; k++) begin : g_slot
    if (k < TLB_ENTRIES - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (update) begin
          if (TLB_USED_W'(k) == last) begin
            tlb_page[k]  <= page;
            tlb_frame[k] <= frame;
          end else if (shift_en && TLB_USED_W'(k) >= shift_from && TLB_USED_W'(k) < last) begin
            tlb_page[k]  <= tlb_page[k+1];
            tlb_frame[k] <= tlb_frame[k+1];
          end
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (update && TLB_USED_W'(k) == last) begin
          tlb_page[k]  <= page;
          tlb_frame[k] <= frame;
        end
      end
    end
  end

  assign tlb_used_next = (update && !hit && !full) ? tlb_used + 1'b1 : tlb_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_used <= '0;
    end else begin
      tlb_used <= tlb_used_next;
    end
  end

  // Valid entries always hold distinct pages.
  a_unique_match: assert property (@(posedge clk) disable iff (rst) $onehot0(match))
    else $error("more than one TLB entry matches the page");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    tlb_used <= TLB_USED_W'(TLB_ENTRIES))
    else $error("TLB fill count exceeds the entry count");

  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    update && !hit && !full |=> tlb_used == $past(tlb_used) + 1'b1)
    else $error("TLB fill count did not grow on a miss");

  a_update_lands: assert property (@(posedge clk) disable iff (rst)
    update |=> lookup.hit || $past(page) != page)
    else $error("updated page is missing from the TLB");

endmodule

`default_nettype wire

// ===== sv/tlb_lru_page_translator.sv =====
// Top level of the address translator: input register, page table, result register.
// Depends on tlbl_pkg and tlbl_lru.
`default_nettype none

// At the accepting edge the address is registered and the page table frame
// memory is read into a register; once the output register is free, the TLB
// compare, the least-recently-used reorder, the page table update and the
// loading of the result register are done together. The single read port of
// the page table memory and the state that each address leaves for the next
// one keep the block from taking a new address until the last one completes.
// A finished result waits in the output register while the next address is
// taken; the block holds that address until the output frees up.
// Page table valid bits sit in flip-flops that reset clears, so no clearing
// pass follows reset.
module tlb_lru_page_translator
  import tlbl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ADDR_W-1:0] logical_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] physical_address,
  output logic              tlb_hit,
  output logic              page_fault
);

  logic                   busy;
  logic                   accept;
  logic                   complete;
  logic [PAGE_BITS-1:0]   in_page;
  logic [PAGE_BITS-1:0]   cur_page;
  logic [OFFSET_BITS-1:0] cur_offset;
  logic [PAGE_COUNT-1:0]  table_valid;
  logic [FRAME_BITS-1:0]  table_frame [PAGE_COUNT];
  logic [FRAME_BITS-1:0]  table_rd;
  logic [FRAME_BITS-1:0]  next_free_frame;
  logic                   fault;
  logic [FRAME_BITS-1:0]  frame;
  tlbl_lookup_t           lookup;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign complete = busy && (!out_valid || !out_stall);
  assign in_page  = PAGE_BITS'(logical_address >> OFFSET_BITS);

  tlbl_lru u_lru (
    .clk    (clk),
    .rst    (rst),
    .page   (cur_page),
    .update (complete),
    .frame  (frame),
    .lookup (lookup)
  );

  assign fault = !lookup.hit && !table_valid[cur_page];

  always_comb begin
    if (lookup.hit) begin
      frame = lookup.frame;
    end else if (table_valid[cur_page]) begin
      frame = table_rd;
    end else begin
      frame = next_free_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      table_rd <= table_frame[in_page];
    end
    if (complete && fault) begin
      table_frame[cur_page] <= next_free_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      out_valid       <= 1'b0;
      table_valid     <= '0;
      next_free_frame <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (complete) begin
        busy <= 1'b0;
      end
      if (complete) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (complete && fault) begin
        table_valid[cur_page] <= 1'b1;
        next_free_frame       <= next_free_frame + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_page   <= in_page;
      cur_offset <= logical_address[OFFSET_BITS-1:0];
    end
    if (complete) begin
      physical_address <= {frame, cur_offset};
      tlb_hit          <= lookup.hit;
      page_fault       <= fault;
    end
  end

  a_hit_no_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tlb_hit && page_fault))
    else $error("result flags both a TLB hit and a page fault");

  a_fault_marks: assert property (@(posedge clk) disable iff (rst)
    complete && fault |=> table_valid[$past(cur_page)])
    else $error("faulting page was not marked valid in the page table");

  a_frame_advance: assert property (@(posedge clk) disable iff (rst)
    complete && fault |=> next_free_frame == FRAME_BITS'($past(next_free_frame) + 1'b1))
    else $error("free frame counter did not advance after a fault");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    busy && !complete |=> busy && $stable(cur_page) && $stable(cur_offset))
    else $error("waiting transaction was lost or changed");

endmodule

`default_nettype wire
